// ----- design/clbs_pkg.sv -----
// Shared constants for the character LCD bus sequencer.
package clbs_pkg;

  localparam int TICK_BITS = 8;

  localparam logic [7:0] LEN_CAP = (TICK_BITS >= 8) ? 8'hFF : 8'((1 << TICK_BITS) - 1);

  localparam int IN_BYTES = 3;
  localparam int OUT_BYTES = 3;

  localparam logic [7:0] BUSY_BIT = 8'h80;

  localparam logic [2:0] REG_FOUR_BIT = 3'd0;
  localparam logic [2:0] REG_SETUP = 3'd1;
  localparam logic [2:0] REG_PULSE = 3'd2;
  localparam logic [2:0] REG_HOLD = 3'd3;
  localparam logic [2:0] REG_CYCLE = 3'd4;
  localparam logic [2:0] REG_READ_DELAY = 3'd5;
  localparam logic [2:0] REG_POLL = 3'd6;

  localparam logic [1:0] ACT_INSTR_WRITE = 2'd0;
  localparam logic [1:0] ACT_DATA_WRITE = 2'd1;
  localparam logic [1:0] ACT_DATA_READ = 2'd2;
  localparam logic [1:0] ACT_STATUS_READ = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       ready_res;
    logic       bus_drive;
    logic [7:0] bus_out;
    logic       enable_line;
    logic       read_not_write;
    logic       reg_select;
  } result_t;

endpackage

// ----- design/char_lcd_bus_sequencer_unit.sv -----
// Top level of the character LCD parallel bus sequencer.
// Each input beat is one tick of the display bus and yields exactly one result beat; a beat
// can be accepted in every cycle while the output side takes results, and its result appears
// in the output register on the next cycle. The per-tick work is a single pass through the
// strobe sequencer state (phase, tick count, nibble, action, held and captured bytes, polling
// flag), so throughput is one beat per cycle whenever the output side takes results.
module char_lcd_bus_sequencer_unit
  import clbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: cmd_valid, cmd_data[7:0], bus_in[7:0], zero fill.
  input  logic [8*IN_BYTES-1:0] s_tdata,
  // Fields from bit 0: action[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: reg_select, read_not_write, enable_line, bus_out[7:0], bus_drive,
  // ready_res, read_valid, read_data[7:0], zero fill.
  output logic [8*OUT_BYTES-1:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_PULSE = 3'd2;
  localparam logic [2:0] PH_HOLD = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;

  logic       four_bit_mode;
  logic [7:0] setup_ticks;
  logic [7:0] pulse_ticks;
  logic [7:0] hold_ticks;
  logic [7:0] cycle_ticks;
  logic [7:0] read_delay_ticks;
  logic       poll_after_instruction;

  logic [2:0]           phase, phase_next;
  logic [TICK_BITS-1:0] tick_count, tick_count_next;
  logic                 second_nibble, second_nibble_next;
  logic [1:0]           current_action, current_action_next;
  logic [7:0]           held_byte, held_byte_next;
  logic [7:0]           captured_byte, captured_byte_next;
  logic                 polling, polling_next;

  result_t res, res_reg;
  logic    in_fire;
  logic    cfg_write;

  logic       cmd_valid;
  logic [1:0] action;
  logic [7:0] cmd_data;
  logic [7:0] bus_in;

  logic [7:0] len_setup, len_pulse, len_hold, len_tail, len_cur, pulse_raw, sample_at;
  logic [9:0] used_ticks;
  logic [7:0] tail_raw;
  logic [TICK_BITS-1:0] tick_inc;
  logic       reading;
  logic       strobe_done;
  logic [2:0] start_phase;

  assign cmd_valid = s_tdata[0];
  assign cmd_data  = s_tdata[8:1];
  assign bus_in    = s_tdata[16:9];
  assign action    = s_tuser;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode          <= 1'b0;
      setup_ticks            <= 8'd3;
      pulse_ticks            <= 8'd14;
      hold_ticks             <= 8'd1;
      cycle_ticks            <= 8'd30;
      read_delay_ticks       <= 8'd10;
      poll_after_instruction <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_FOUR_BIT:   four_bit_mode <= pwdata[0];
        REG_SETUP:      setup_ticks <= pwdata[7:0];
        REG_PULSE:      pulse_ticks <= pwdata[7:0];
        REG_HOLD:       hold_ticks <= pwdata[7:0];
        REG_CYCLE:      cycle_ticks <= pwdata[7:0];
        REG_READ_DELAY: read_delay_ticks <= pwdata[7:0];
        REG_POLL:       poll_after_instruction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FOUR_BIT:   prdata = {31'd0, four_bit_mode};
      REG_SETUP:      prdata = {24'd0, setup_ticks};
      REG_PULSE:      prdata = {24'd0, pulse_ticks};
      REG_HOLD:       prdata = {24'd0, hold_ticks};
      REG_CYCLE:      prdata = {24'd0, cycle_ticks};
      REG_READ_DELAY: prdata = {24'd0, read_delay_ticks};
      REG_POLL:       prdata = {31'd0, poll_after_instruction};
      default:        prdata = 32'd0;
    endcase
  end

  // Phase lengths; a zero pulse length counts as one tick.
  always_comb begin
    pulse_raw  = (pulse_ticks == 8'd0) ? 8'd1 : pulse_ticks;
    used_ticks = 10'(setup_ticks) + 10'(pulse_raw) + 10'(hold_ticks);
    tail_raw   = (10'(cycle_ticks) > used_ticks) ? 8'(10'(cycle_ticks) - used_ticks) : 8'd0;
    len_setup  = (setup_ticks > LEN_CAP) ? LEN_CAP : setup_ticks;
    len_pulse  = (pulse_raw > LEN_CAP) ? LEN_CAP : pulse_raw;
    len_hold   = (hold_ticks > LEN_CAP) ? LEN_CAP : hold_ticks;
    len_tail   = (tail_raw > LEN_CAP) ? LEN_CAP : tail_raw;
    unique case (phase)
      PH_SETUP: len_cur = len_setup;
      PH_PULSE: len_cur = len_pulse;
      PH_HOLD:  len_cur = len_hold;
      PH_TAIL:  len_cur = len_tail;
      default:  len_cur = 8'd0;
    endcase
    sample_at   = (read_delay_ticks < len_pulse) ? read_delay_ticks : len_pulse - 8'd1;
    start_phase = (len_setup != 8'd0) ? PH_SETUP : PH_PULSE;
  end

  assign tick_inc = tick_count + TICK_BITS'(1);
  assign reading  = polling || current_action[1];

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    second_nibble_next  = second_nibble;
    current_action_next = current_action;
    held_byte_next      = held_byte;
    captured_byte_next  = captured_byte;
    polling_next        = polling;
    strobe_done         = 1'b0;
    res                 = '0;

    if (phase == PH_IDLE || phase > PH_TAIL) begin
      phase_next = PH_IDLE;
      if (cmd_valid) begin
        res.ready_res       = 1'b1;
        current_action_next = action;
        held_byte_next      = cmd_data;
        second_nibble_next  = 1'b0;
        polling_next        = 1'b0;
        tick_count_next     = '0;
        phase_next          = start_phase;
      end
    end else begin
      res.reg_select     = !polling && (current_action == ACT_DATA_WRITE ||
                                        current_action == ACT_DATA_READ);
      res.read_not_write = reading;
      res.enable_line    = (phase == PH_PULSE);
      if (!reading) begin
        res.bus_drive = 1'b1;
        res.bus_out   = second_nibble ? {held_byte[3:0], 4'd0} : held_byte;
      end else if (phase == PH_PULSE && 32'(tick_count) == 32'(sample_at)) begin
        captured_byte_next = second_nibble ? {captured_byte[7:4], bus_in[7:4]} : bus_in;
      end

      if (tick_inc != '0 && 32'(tick_inc) < 32'(len_cur)) begin
        tick_count_next = tick_inc;
      end else begin
        tick_count_next = '0;
        priority if (phase == PH_SETUP) begin
          phase_next = PH_PULSE;
        end else if (phase == PH_PULSE && len_hold != 8'd0) begin
          phase_next = PH_HOLD;
        end else if ((phase == PH_PULSE || phase == PH_HOLD) && len_tail != 8'd0) begin
          phase_next = PH_TAIL;
        end else begin
          strobe_done = 1'b1;
        end
      end

      if (strobe_done) begin
        if (four_bit_mode && !second_nibble) begin
          second_nibble_next = 1'b1;
          phase_next         = start_phase;
        end else begin
          second_nibble_next = 1'b0;
          if (polling) begin
            if ((captured_byte_next & BUSY_BIT) != 8'd0) begin
              phase_next = start_phase;
            end else begin
              polling_next = 1'b0;
              phase_next   = PH_IDLE;
            end
          end else if (current_action == ACT_INSTR_WRITE && poll_after_instruction) begin
            polling_next = 1'b1;
            phase_next   = start_phase;
          end else begin
            phase_next = PH_IDLE;
            if (current_action == ACT_DATA_READ || current_action == ACT_STATUS_READ) begin
              res.read_valid = 1'b1;
              res.read_data  = captured_byte_next;
            end
          end
        end
      end
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      second_nibble  <= 1'b0;
      current_action <= ACT_INSTR_WRITE;
      held_byte      <= 8'd0;
      captured_byte  <= 8'd0;
      polling        <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (in_fire) begin
        phase          <= phase_next;
        tick_count     <= tick_count_next;
        second_nibble  <= second_nibble_next;
        current_action <= current_action_next;
        held_byte      <= held_byte_next;
        captured_byte  <= captured_byte_next;
        polling        <= polling_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_reg <= res;
    end
  end

  assign m_tdata = {{(8*OUT_BYTES-$bits(result_t)){1'b0}}, res_reg};

endmodule
